>>> src/ircmfs_pkg.sv
// ----------------------------------------------------------------------------
// ircmfs_pkg
// Shared types and constants for the IRC message field splitter.
// ----------------------------------------------------------------------------
package ircmfs_pkg;

	// Characters with a special meaning in a message line.
	localparam logic [7:0] SPACE_CH = 8'h20;
	localparam logic [7:0] AT_CH    = 8'h40;
	localparam logic [7:0] COLON_CH = 8'h3A;

	// Bound on the number of parameters that get an index of their own.
	localparam int unsigned MAX_PARAMS = 15;
	localparam logic [3:0]  MAX_PARAMS_C = 4'(MAX_PARAMS);

	// Field that the current or last token belongs to.
	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_TAG   = 3'd1,
		PH_SRC   = 3'd2,
		PH_CMD   = 3'd3,
		PH_MID   = 3'd4,
		PH_TRAIL = 3'd5
	} phase_t;

	// Label given to each byte.
	typedef enum logic [2:0] {
		ROLE_DROP  = 3'd0,
		ROLE_TAG   = 3'd1,
		ROLE_SRC   = 3'd2,
		ROLE_CMD   = 3'd3,
		ROLE_MID   = 3'd4,
		ROLE_TRAIL = 3'd5
	} role_t;

	// Parser state carried from byte to byte.
	typedef struct packed {
		phase_t     phase;
		logic [3:0] param_count;
		logic       token_open;
		logic       pending_space;
		logic       overflow_seen;
		logic       field_fresh;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_START,
		param_count:   4'd0,
		token_open:    1'b0,
		pending_space: 1'b0,
		overflow_seen: 1'b0,
		field_fresh:   1'b0
	};

	// One labeled byte.
	typedef struct packed {
		logic       param_overflow;
		logic       space_before;
		logic       field_start;
		logic [3:0] param_index;
		logic [7:0] byte_value;
		role_t      byte_role;
	} result_t;

endpackage

>>> src/ircmfs_classify.sv
// ----------------------------------------------------------------------------
// ircmfs_classify
// Labels one byte from the current parser state and computes the next state.
// ----------------------------------------------------------------------------
module ircmfs_classify (
	input  ircmfs_pkg::state_t  state,
	input  logic [7:0]          msg_byte,
	input  logic                msg_end,
	output ircmfs_pkg::state_t  state_next,
	output ircmfs_pkg::result_t result
);

	ircmfs_pkg::state_t ns;
	ircmfs_pkg::role_t  role;
	logic               marker;
	logic               fs;
	logic               sb;
	logic [3:0]         idx;

	// Token tracking, phase changes and role of the byte.
	always_comb begin
		ns     = state;
		marker = 1'b0;
		role   = ircmfs_pkg::ROLE_DROP;
		fs     = 1'b0;
		sb     = 1'b0;
		idx    = 4'd0;

		if (msg_byte == ircmfs_pkg::SPACE_CH) begin
			if (state.phase == ircmfs_pkg::PH_TRAIL) begin
				ns.pending_space = 1'b1;
			end
			ns.token_open = 1'b0;
		end else begin
			// A new token decides which field comes next.
			if (!state.token_open) begin
				ns.token_open = 1'b1;
				case (state.phase)
					ircmfs_pkg::PH_START: begin
						ns.field_fresh = 1'b1;
						if (msg_byte == ircmfs_pkg::AT_CH) begin
							ns.phase = ircmfs_pkg::PH_TAG;
							marker   = 1'b1;
						end else if (msg_byte == ircmfs_pkg::COLON_CH) begin
							ns.phase = ircmfs_pkg::PH_SRC;
							marker   = 1'b1;
						end else begin
							ns.phase = ircmfs_pkg::PH_CMD;
						end
					end
					ircmfs_pkg::PH_TAG: begin
						ns.field_fresh = 1'b1;
						if (msg_byte == ircmfs_pkg::COLON_CH) begin
							ns.phase = ircmfs_pkg::PH_SRC;
							marker   = 1'b1;
						end else begin
							ns.phase = ircmfs_pkg::PH_CMD;
						end
					end
					ircmfs_pkg::PH_SRC: begin
						ns.field_fresh = 1'b1;
						ns.phase       = ircmfs_pkg::PH_CMD;
					end
					ircmfs_pkg::PH_CMD, ircmfs_pkg::PH_MID: begin
						// Open a parameter; the index saturates at the bound.
						ns.field_fresh = 1'b1;
						if (state.param_count < ircmfs_pkg::MAX_PARAMS_C) begin
							ns.param_count = state.param_count + 4'd1;
						end else begin
							ns.overflow_seen = 1'b1;
						end
						if (msg_byte == ircmfs_pkg::COLON_CH) begin
							ns.phase         = ircmfs_pkg::PH_TRAIL;
							ns.pending_space = 1'b0;
							marker           = 1'b1;
						end else begin
							ns.phase = ircmfs_pkg::PH_MID;
						end
					end
					default: begin
					end
				endcase
			end

			// Kept bytes take their role from the phase.
			if (!marker) begin
				case (ns.phase)
					ircmfs_pkg::PH_TAG:   role = ircmfs_pkg::ROLE_TAG;
					ircmfs_pkg::PH_SRC:   role = ircmfs_pkg::ROLE_SRC;
					ircmfs_pkg::PH_CMD:   role = ircmfs_pkg::ROLE_CMD;
					ircmfs_pkg::PH_MID:   role = ircmfs_pkg::ROLE_MID;
					ircmfs_pkg::PH_TRAIL: role = ircmfs_pkg::ROLE_TRAIL;
					default:              role = ircmfs_pkg::ROLE_DROP;
				endcase
				if (role != ircmfs_pkg::ROLE_DROP) begin
					fs             = ns.field_fresh;
					ns.field_fresh = 1'b0;
					if ((role == ircmfs_pkg::ROLE_MID || role == ircmfs_pkg::ROLE_TRAIL)
						&& ns.param_count != 4'd0) begin
						idx = ns.param_count - 4'd1;
					end
					if (role == ircmfs_pkg::ROLE_TRAIL) begin
						sb               = ns.pending_space;
						ns.pending_space = 1'b0;
					end
				end
			end
		end
	end

	// Result fields and end-of-message clear.
	always_comb begin
		result.byte_role      = role;
		result.byte_value     = msg_byte;
		result.param_index    = idx;
		result.field_start    = fs;
		result.space_before   = sb;
		result.param_overflow = ns.overflow_seen;
		state_next            = msg_end ? ircmfs_pkg::STATE_RESET : ns;
	end

endmodule

>>> src/irc_message_field_splitter.sv
// ----------------------------------------------------------------------------
// irc_message_field_splitter
// Labels each byte of an IRC message line with the field it belongs to.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Beat contents
// s_axis   in   tdata[7:0] msg_byte; tlast msg_end
// m_axis   out  tdata: byte_role, byte_value, param_index, field_start,
//               space_before, param_overflow; tlast message_done
//
// One byte per cycle is sustained while m_axis_tready is high; an accepted byte
// passes through the input register, then the result register, to the output.
// The parser state advances as a byte moves from the input register to the
// result register, so consecutive bytes see each other's updates.
// Reset (arst_n low) returns the parser to the start of a message.
// A stall on m_axis fills the result register, then the input register,
// and only then drops s_axis_tready.
// ----------------------------------------------------------------------------
module irc_message_field_splitter (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
	input  logic        s_axis_tlast,   // msg_end

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [2:0] byte_role, [10:3] byte_value,
	                                    // [14:11] param_index, [15] field_start,
	                                    // [16] space_before, [17] param_overflow,
	                                    // [23:18] zero
	output logic        m_axis_tlast    // message_done
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                valid_s2;
	ircmfs_pkg::result_t result_s2;
	logic                end_s2;
	ircmfs_pkg::state_t  state_q;
	ircmfs_pkg::state_t  state_next;
	ircmfs_pkg::result_t result;
	logic                adv_s1;

	// Stage 1 moves on when the result register is free or being emptied.
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	ircmfs_classify u_classify (
		.state      (state_q),
		.msg_byte   (byte_s1),
		.msg_end    (end_s1),
		.state_next (state_next),
		.result     (result)
	);

	// Parser state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ircmfs_pkg::STATE_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_next;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
			end_s2    <= end_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, result_s2};
	assign m_axis_tlast  = end_s2;

endmodule
